// ===== src/palf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_pkg: shared types and constants of the principal axis line fit
// Field widths, fixed-point constants, sequencer codes and queue status.
// ----------------------------------------------------------------------------
package palf_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CNT_BITS       = 25;
  localparam int FIELD_BITS     = 12;
  localparam int SLOPE_BITS     = 32;
  localparam int CENT_MAX       = 4095;
  localparam int QUEUE_DEPTH    = 2;

  // multiplier digit, fixed-point fraction and normalized operand size
  localparam int MUL_DIGIT  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int NORM_BITS  = 31;

  // square root of a sum of two 31-bit squares
  localparam int SQRT_IN_W   = 64;
  localparam int SQRT_ROOT_W = 32;
  localparam int SQRT_REM_W  = 36;

  // numerator / denominator and the shared divider
  localparam int NUM_W     = 35;
  localparam int DIV_DVD_W = 51;
  localparam int DIV_DVS_W = 35;

  localparam logic [SLOPE_BITS-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
  localparam logic [SLOPE_BITS-1:0] SLOPE_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_MLD,
    BS_MUL,
    BS_ABS,
    BS_NORM,
    BS_SQRT,
    BS_NUM,
    BS_CHK,
    BS_DIV,
    BS_OUT
  } palf_bstate_t;

  typedef enum logic [2:0] {
    OP_N_D,
    OP_SY2,
    OP_SX2,
    OP_N_XY,
    OP_SX_SY,
    OP_E2,
    OP_F2
  } palf_op_t;

  typedef enum logic [1:0] {
    DS_SLOPE,
    DS_ROW,
    DS_COL
  } palf_dsel_t;

  typedef struct packed {
    logic full;
    logic valid;
  } palf_qstat_t;

endpackage

`default_nettype wire

// ===== src/palf_pix_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_pix_if: pixel input channel
// Valid/ready handshake carrying one pixel item.
// ----------------------------------------------------------------------------
interface palf_pix_if;
  import palf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  pixel_on;
  logic [FIELD_BITS-1:0] pixel_row;
  logic [FIELD_BITS-1:0] pixel_col;
  logic                  window_last;

  modport source (output valid, pixel_on, pixel_row, pixel_col, window_last,
                  input ready);
  modport sink   (input valid, pixel_on, pixel_row, pixel_col, window_last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/palf_fit_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_fit_if: fit result channel
// Valid/ready handshake carrying one line fit item per window.
// ----------------------------------------------------------------------------
interface palf_fit_if;
  import palf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SLOPE_BITS-1:0] fit_slope;
  logic [FIELD_BITS-1:0]        centroid_row;
  logic [FIELD_BITS-1:0]        centroid_col;
  logic                         window_empty;

  modport source (output valid, fit_slope, centroid_row, centroid_col, window_empty,
                  input ready);
  modport sink   (input valid, fit_slope, centroid_row, centroid_col, window_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== src/palf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_front: moment accumulator
// Accumulates count, sums, squares and cross product of foreground pixels,
// one item per cycle unless the queue is full; pushes moments on window end.
// ----------------------------------------------------------------------------
module palf_front #(
  parameter int COORD_BITS = palf_pkg::COORD_BITS_DEF,
  parameter int MOM_W      = 1
) (
  input  wire                       clk,
  input  wire                       rst_n,
  palf_pix_if.sink                  in_pix,
  input  palf_pkg::palf_qstat_t     qstat,
  output logic                      push,
  output logic [MOM_W-1:0]          mom_data
);
  import palf_pkg::*;

  localparam int SUM_W = CNT_BITS + COORD_BITS;
  localparam int SQ_W  = CNT_BITS + 2 * COORD_BITS;

  logic [COORD_BITS-1:0]   r_w, c_w;
  logic [2*COORD_BITS-1:0] rr_w, rc_w, cc_w;
  logic                    acc_w;

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SQ_W-1:0]     sxx_r, sxx_nxt, sxy_r, sxy_nxt, syy_r, syy_nxt;

  assign r_w  = COORD_BITS'(in_pix.pixel_row);
  assign c_w  = COORD_BITS'(in_pix.pixel_col);
  assign rr_w = r_w * r_w;
  assign rc_w = r_w * c_w;
  assign cc_w = c_w * c_w;

  assign in_pix.ready = !qstat.full;
  assign acc_w        = in_pix.valid && in_pix.ready;
  assign push         = acc_w && in_pix.window_last;
  assign mom_data     = {cnt_nxt, sx_nxt, sy_nxt, sxx_nxt, sxy_nxt, syy_nxt};

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxx_nxt = sxx_r;
    sxy_nxt = sxy_r;
    syy_nxt = syy_r;
    if (in_pix.pixel_on) begin
      cnt_nxt = cnt_r + 1'b1;
      sx_nxt  = sx_r + SUM_W'(r_w);
      sy_nxt  = sy_r + SUM_W'(c_w);
      sxx_nxt = sxx_r + SQ_W'(rr_w);
      sxy_nxt = sxy_r + SQ_W'(rc_w);
      syy_nxt = syy_r + SQ_W'(cc_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
      syy_r <= '0;
    end else if (acc_w) begin
      if (in_pix.window_last) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxx_r <= '0;
        sxy_r <= '0;
        syy_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        sxx_r <= sxx_nxt;
        sxy_r <= sxy_nxt;
        syy_r <= syy_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/palf_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_fifo: window snapshot queue
// Short register queue between the accumulator and the fit engine.
// ----------------------------------------------------------------------------
module palf_fifo #(
  parameter int W = 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire [W-1:0]           wdata,
  input  wire                   pop,
  output palf_pkg::palf_qstat_t qstat,
  output logic [W-1:0]          rdata
);
  import palf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign qstat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign qstat.valid = (cnt_r != '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && qstat.valid;
  assign rdata       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end

endmodule

`default_nettype wire

// ===== src/palf_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_div: restoring divider
// Unsigned quotient, one bit per cycle; done pulses when quotient is valid.
// ----------------------------------------------------------------------------
module palf_div #(
  parameter int DVD_W = palf_pkg::DIV_DVD_W,
  parameter int DVS_W = palf_pkg::DIV_DVS_W
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire [DVD_W-1:0]   dividend,
  input  wire [DVS_W-1:0]   divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r, rem_r;
  logic [DVS_W:0]   rem_s, rem_d;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r, qbit;

  assign rem_s    = {rem_r, dvd_r[DVD_W-1]};
  assign qbit     = (rem_s >= {1'b0, dvs_r});
  assign rem_d    = rem_s - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CW'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? rem_d[DVS_W-1:0] : rem_s[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

// ===== src/palf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palf_back: line fit engine
// Sequencer over a shared digit multiplier, a normalizer, a bit-serial
// square root and a shared divider; holds the result in an output register.
// ----------------------------------------------------------------------------
module palf_back #(
  parameter int COORD_BITS = palf_pkg::COORD_BITS_DEF,
  parameter int MOM_W      = 1
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  palf_pkg::palf_qstat_t qstat,
  input  wire [MOM_W-1:0]       mom_data,
  output logic                  pop,
  palf_fit_if.source            out_fit
);
  import palf_pkg::*;

  localparam int SUM_W = CNT_BITS + COORD_BITS;
  localparam int SQ_W  = CNT_BITS + 2 * COORD_BITS;
  localparam int MA    = SQ_W + 1;
  localparam int ND    = (MA + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int MB    = ND * MUL_DIGIT;
  localparam int MP    = MA + MB;
  localparam int MCW   = $clog2(ND + 1);
  localparam int EW    = 2 * SUM_W + 3;
  localparam int SCW   = $clog2(SQRT_ROOT_W);

  // snapshot fields
  logic [CNT_BITS-1:0] n_w;
  logic [SUM_W-1:0]    sx_w, sy_w;
  logic [SQ_W-1:0]     sxx_w, sxy_w, syy_w;

  assign {n_w, sx_w, sy_w, sxx_w, sxy_w, syy_w} = mom_data;

  palf_bstate_t state_r, state_nxt;
  palf_op_t     op_r, op_nxt;
  palf_dsel_t   dsel_r, dsel_nxt;
  logic         ov_r, ov_nxt;
  logic [MCW-1:0] mcnt_r, mcnt_nxt;
  logic [SCW-1:0] scnt_r, scnt_nxt;

  logic [CNT_BITS-1:0]     n_r, n_nxt;
  logic [SUM_W-1:0]        sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SQ_W-1:0]         sxy_r, sxy_nxt;
  logic signed [SQ_W:0]    d_r, d_nxt;
  logic [MA-1:0]           mul_a_r, mul_a_nxt, mop_a;
  logic [MB-1:0]           mul_b_r, mul_b_nxt, mop_b;
  logic [MP-1:0]           macc_r, macc_nxt;
  logic [MA+MUL_DIGIT-1:0] mprod;
  logic signed [EW-1:0]    e_r, e_nxt, f_r, f_nxt, p_w, f2_w;
  logic [EW-1:0]           me_r, me_nxt, mf_r, mf_nxt;
  logic                    eneg_r, eneg_nxt, fneg_r, fneg_nxt;
  logic [SQRT_IN_W-1:0]    q_r, q_nxt;
  logic [SQRT_REM_W-1:0]   rem_r, rem_nxt, rem_s, trial;
  logic [SQRT_ROOT_W-1:0]  root_r, root_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt, den_r, den_nxt, es_w, fs_w, dd_w;
  logic [NUM_W-1:0]        num_mag, den_mag;
  logic                    sneg_r, sneg_nxt;
  logic [SLOPE_BITS-1:0]   slope_r, slope_nxt;
  logic [FIELD_BITS-1:0]   crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic                    empty_r, empty_nxt;
  logic [SLOPE_BITS-1:0]   o_slope_r, o_slope_nxt;
  logic [FIELD_BITS-1:0]   o_row_r, o_row_nxt, o_col_r, o_col_nxt;
  logic                    o_empty_r, o_empty_nxt;

  logic                    div_start, div_done;
  logic [DIV_DVD_W-1:0]    div_dvd, div_q, div_qc;
  logic [DIV_DVS_W-1:0]    div_dvs;
  logic [FIELD_BITS-1:0]   cent_w;

  palf_div #(.DVD_W(DIV_DVD_W), .DVS_W(DIV_DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_fit.valid        = ov_r;
  assign out_fit.fit_slope    = $signed(o_slope_r);
  assign out_fit.centroid_row = o_row_r;
  assign out_fit.centroid_col = o_col_r;
  assign out_fit.window_empty = o_empty_r;

  assign mprod = mul_a_r * mul_b_r[MB-1 -: MUL_DIGIT];
  assign p_w   = $signed(macc_r[EW-1:0]);
  assign f2_w  = f_r <<< 1;
  assign rem_s = {rem_r[SQRT_REM_W-3:0], q_r[SQRT_IN_W-1 -: 2]};
  assign trial = SQRT_REM_W'({root_r, 2'b01});
  assign num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : num_r;
  assign den_mag = den_r[NUM_W-1] ? NUM_W'(-den_r) : den_r;
  assign cent_w  = (div_q > DIV_DVD_W'(CENT_MAX)) ? FIELD_BITS'(CENT_MAX)
                                                   : div_q[FIELD_BITS-1:0];
  assign div_qc  = (div_q > DIV_DVD_W'(SLOPE_MIN)) ? DIV_DVD_W'(SLOPE_MIN) : div_q;

  // multiplier operands per step
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (op_r)
      OP_N_D: begin
        mop_a = MA'(n_r);
        mop_b = MB'(d_r[SQ_W] ? (-d_r) : d_r);
      end
      OP_SY2: begin
        mop_a = MA'(sy_r);
        mop_b = MB'(sy_r);
      end
      OP_SX2: begin
        mop_a = MA'(sx_r);
        mop_b = MB'(sx_r);
      end
      OP_N_XY: begin
        mop_a = MA'(n_r);
        mop_b = MB'(sxy_r);
      end
      OP_SX_SY: begin
        mop_a = MA'(sx_r);
        mop_b = MB'(sy_r);
      end
      OP_E2: begin
        mop_a = MA'(me_r[NORM_BITS-1:0]);
        mop_b = MB'(me_r[NORM_BITS-1:0]);
      end
      OP_F2: begin
        mop_a = MA'(mf_r[NORM_BITS-1:0]);
        mop_b = MB'(mf_r[NORM_BITS-1:0]);
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    dsel_nxt  = dsel_r;
    ov_nxt    = ov_r;
    mcnt_nxt  = mcnt_r;
    scnt_nxt  = scnt_r;
    n_nxt     = n_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sxy_nxt   = sxy_r;
    d_nxt     = d_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    macc_nxt  = macc_r;
    e_nxt     = e_r;
    f_nxt     = f_r;
    me_nxt    = me_r;
    mf_nxt    = mf_r;
    eneg_nxt  = eneg_r;
    fneg_nxt  = fneg_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    sneg_nxt  = sneg_r;
    slope_nxt = slope_r;
    crow_nxt  = crow_r;
    ccol_nxt  = ccol_r;
    empty_nxt = empty_r;
    o_slope_nxt = o_slope_r;
    o_row_nxt   = o_row_r;
    o_col_nxt   = o_col_r;
    o_empty_nxt = o_empty_r;
    pop       = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    es_w      = '0;
    fs_w      = '0;
    dd_w      = '0;

    if (ov_r && out_fit.ready) ov_nxt = 1'b0;

    case (state_r)
      BS_IDLE: begin
        if (qstat.valid) begin
          pop     = 1'b1;
          n_nxt   = n_w;
          sx_nxt  = sx_w;
          sy_nxt  = sy_w;
          sxy_nxt = sxy_w;
          d_nxt   = $signed({1'b0, syy_w}) - $signed({1'b0, sxx_w});
          if (n_w == '0) begin
            slope_nxt = '0;
            crow_nxt  = '0;
            ccol_nxt  = '0;
            empty_nxt = 1'b1;
            state_nxt = BS_OUT;
          end else begin
            empty_nxt = 1'b0;
            op_nxt    = OP_N_D;
            state_nxt = BS_MLD;
          end
        end
      end
      BS_MLD: begin
        mul_a_nxt = mop_a;
        mul_b_nxt = mop_b;
        macc_nxt  = '0;
        mcnt_nxt  = '0;
        state_nxt = BS_MUL;
      end
      BS_MUL: begin
        if (mcnt_r != MCW'(ND)) begin
          // most significant digit first, so the running sum shifts by a digit
          macc_nxt  = {macc_r[MP-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}} + MP'(mprod);
          mul_b_nxt = mul_b_r << MUL_DIGIT;
          mcnt_nxt  = mcnt_r + 1'b1;
        end else begin
          state_nxt = BS_MLD;
          case (op_r)
            OP_N_D: begin
              e_nxt  = d_r[SQ_W] ? (-p_w) : p_w;
              op_nxt = OP_SY2;
            end
            OP_SY2: begin
              e_nxt  = e_r - p_w;
              op_nxt = OP_SX2;
            end
            OP_SX2: begin
              e_nxt  = e_r + p_w;
              op_nxt = OP_N_XY;
            end
            OP_N_XY: begin
              f_nxt  = p_w;
              op_nxt = OP_SX_SY;
            end
            OP_SX_SY: begin
              f_nxt     = f_r - p_w;
              state_nxt = BS_ABS;
            end
            OP_E2: begin
              q_nxt  = macc_r[SQRT_IN_W-1:0];
              op_nxt = OP_F2;
            end
            OP_F2: begin
              q_nxt     = q_r + macc_r[SQRT_IN_W-1:0];
              rem_nxt   = '0;
              root_nxt  = '0;
              scnt_nxt  = '0;
              state_nxt = BS_SQRT;
            end
            default: state_nxt = BS_IDLE;
          endcase
        end
      end
      BS_ABS: begin
        eneg_nxt  = e_r[EW-1];
        fneg_nxt  = f2_w[EW-1];
        me_nxt    = e_r[EW-1] ? EW'(-e_r) : EW'(e_r);
        mf_nxt    = f2_w[EW-1] ? EW'(-f2_w) : EW'(f2_w);
        state_nxt = BS_NORM;
      end
      BS_NORM: begin
        // shift both magnitudes together until each fits the normalized size
        if ((|me_r[EW-1:NORM_BITS]) || (|mf_r[EW-1:NORM_BITS])) begin
          me_nxt = me_r >> 1;
          mf_nxt = mf_r >> 1;
        end else begin
          op_nxt    = OP_E2;
          state_nxt = BS_MLD;
        end
      end
      BS_SQRT: begin
        q_nxt = q_r << 2;
        if (rem_s >= trial) begin
          rem_nxt  = rem_s - trial;
          root_nxt = {root_r[SQRT_ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_s;
          root_nxt = {root_r[SQRT_ROOT_W-2:0], 1'b0};
        end
        scnt_nxt = scnt_r + 1'b1;
        if (scnt_r == SCW'(SQRT_ROOT_W - 1)) state_nxt = BS_NUM;
      end
      BS_NUM: begin
        es_w = $signed(NUM_W'(me_r[NORM_BITS-1:0]));
        fs_w = $signed(NUM_W'(mf_r[NORM_BITS-1:0]));
        if (eneg_r) es_w = -es_w;
        if (fneg_r) fs_w = -fs_w;
        dd_w      = $signed(NUM_W'(root_r));
        num_nxt   = es_w - fs_w + dd_w;
        den_nxt   = es_w + fs_w - dd_w;
        state_nxt = BS_CHK;
      end
      BS_CHK: begin
        state_nxt = BS_DIV;
        div_start = 1'b1;
        if (den_r == '0) begin
          // zero denominator: saturate by numerator sign, zero over zero is 0
          if (num_r == '0)          slope_nxt = '0;
          else if (num_r[NUM_W-1])  slope_nxt = SLOPE_MIN;
          else                      slope_nxt = SLOPE_MAX;
          dsel_nxt = DS_ROW;
          div_dvd  = DIV_DVD_W'(sx_r);
          div_dvs  = DIV_DVS_W'(n_r);
        end else begin
          sneg_nxt = num_r[NUM_W-1] != den_r[NUM_W-1];
          dsel_nxt = DS_SLOPE;
          div_dvd  = DIV_DVD_W'({num_mag, {FRAC_BITS{1'b0}}});
          div_dvs  = DIV_DVS_W'(den_mag);
        end
      end
      BS_DIV: begin
        if (div_done) begin
          case (dsel_r)
            DS_SLOPE: begin
              if (sneg_r)
                slope_nxt = SLOPE_BITS'(~div_qc[SLOPE_BITS-1:0] + 1'b1);
              else if (div_q > DIV_DVD_W'(SLOPE_MAX))
                slope_nxt = SLOPE_MAX;
              else
                slope_nxt = div_q[SLOPE_BITS-1:0];
              dsel_nxt  = DS_ROW;
              div_start = 1'b1;
              div_dvd   = DIV_DVD_W'(sx_r);
              div_dvs   = DIV_DVS_W'(n_r);
            end
            DS_ROW: begin
              crow_nxt  = cent_w;
              dsel_nxt  = DS_COL;
              div_start = 1'b1;
              div_dvd   = DIV_DVD_W'(sy_r);
              div_dvs   = DIV_DVS_W'(n_r);
            end
            DS_COL: begin
              ccol_nxt  = cent_w;
              state_nxt = BS_OUT;
            end
            default: state_nxt = BS_OUT;
          endcase
        end
      end
      BS_OUT: begin
        if (!ov_r || out_fit.ready) begin
          o_slope_nxt = slope_r;
          o_row_nxt   = crow_r;
          o_col_nxt   = ccol_r;
          o_empty_nxt = empty_r;
          ov_nxt      = 1'b1;
          state_nxt   = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      op_r    <= OP_N_D;
      dsel_r  <= DS_SLOPE;
      ov_r    <= 1'b0;
      mcnt_r  <= '0;
      scnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      dsel_r  <= dsel_nxt;
      ov_r    <= ov_nxt;
      mcnt_r  <= mcnt_nxt;
      scnt_r  <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    sxy_r     <= sxy_nxt;
    d_r       <= d_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    macc_r    <= macc_nxt;
    e_r       <= e_nxt;
    f_r       <= f_nxt;
    me_r      <= me_nxt;
    mf_r      <= mf_nxt;
    eneg_r    <= eneg_nxt;
    fneg_r    <= fneg_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    sneg_r    <= sneg_nxt;
    slope_r   <= slope_nxt;
    crow_r    <= crow_nxt;
    ccol_r    <= ccol_nxt;
    empty_r   <= empty_nxt;
    o_slope_r <= o_slope_nxt;
    o_row_r   <= o_row_nxt;
    o_col_r   <= o_col_nxt;
    o_empty_r <= o_empty_nxt;
  end

endmodule

`default_nettype wire

// ===== src/principal_axis_line_fit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// principal_axis_line_fit_top: principal axis line fit of a pixel window
// Accumulates pixel moments and, per window, gives slope, centroid and empty.
//
//   channel  dir  handshake      payload
//   in_pix   in   valid/ready    pixel_on, pixel_row, pixel_col, window_last
//   out_fit  out  valid/ready    fit_slope, centroid_row, centroid_col,
//                                window_empty
//
// Pixels are taken one per cycle; the accumulator waits only while the
// queue is full. The fit uses seven products on the shared digit multiplier,
// up to about 46 normalizing shifts, 32 square root steps and three
// divisions (two on a zero denominator); empty windows skip the math.
// A two-entry snapshot queue lets two finished windows wait; in_pix.ready
// drops only while it is full. Synchronous active-low reset clears the sums.
// ----------------------------------------------------------------------------
module principal_axis_line_fit_top #(
  parameter int COORD_BITS = palf_pkg::COORD_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  palf_pix_if.sink    in_pix,
  palf_fit_if.source  out_fit
);
  import palf_pkg::*;

  localparam int SUM_W = CNT_BITS + COORD_BITS;
  localparam int SQ_W  = CNT_BITS + 2 * COORD_BITS;
  localparam int MOM_W = CNT_BITS + 2 * SUM_W + 3 * SQ_W;

  palf_qstat_t      qstat;
  logic             push, pop;
  logic [MOM_W-1:0] wr_mom, rd_mom;

  palf_front #(.COORD_BITS(COORD_BITS), .MOM_W(MOM_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .qstat    (qstat),
    .push     (push),
    .mom_data (wr_mom)
  );

  palf_fifo #(.W(MOM_W)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wr_mom),
    .pop   (pop),
    .qstat (qstat),
    .rdata (rd_mom)
  );

  palf_back #(.COORD_BITS(COORD_BITS), .MOM_W(MOM_W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .mom_data (rd_mom),
    .pop      (pop),
    .out_fit  (out_fit)
  );

`ifndef SYNTHESIS
  // an empty window reports all-zero slope and centroid
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_fit.valid && out_fit.window_empty |->
      out_fit.fit_slope == 0 && out_fit.centroid_row == 0 && out_fit.centroid_col == 0)
    else $error("empty window item with nonzero fields");

  // a closed window is waiting in the queue on the next cycle
  a_window_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready && in_pix.window_last |=> qstat.valid)
    else $error("closed window missing from queue");

  // the engine only dequeues a snapshot that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.valid)
    else $error("dequeue from empty queue");
`endif

endmodule

`default_nettype wire

// ===== dv/principal_axis_line_fit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// principal_axis_line_fit_top_tb: self-checking bench for the line fit block
// Streams pixel windows (a directed table, then random windows, mostly points
// scattered around a line) with random idling on both sides. A moment model
// predicts slope, centroid and empty flag of every window; results are
// checked field by field in order.
// ----------------------------------------------------------------------------
module principal_axis_line_fit_top_tb;
  import palf_pkg::*;

  localparam int N_ITEMS   = 1650;
  localparam int LONG_HOLD = 3000;

  typedef struct packed {
    logic signed [SLOPE_BITS-1:0] slope;
    logic [FIELD_BITS-1:0]        crow;
    logic [FIELD_BITS-1:0]        ccol;
    logic                         empty;
  } fit_t;

  typedef struct {
    logic                  on;
    logic [FIELD_BITS-1:0] row;
    logic [FIELD_BITS-1:0] col;
    logic                  last;
    logic                  known;  // expected fit typed in below
    fit_t                  fit;
  } pix_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  palf_pix_if in_pix ();
  palf_fit_if out_fit ();

  principal_axis_line_fit_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_pix.sink),
    .out_fit(out_fit.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // moment sums of the current window
  logic [CNT_BITS-1:0]        n_pix;
  logic [CNT_BITS+11:0]       row_sum, col_sum;
  logic [CNT_BITS+23:0]       row_sq, cross_sum, col_sq;

  fit_t fit_q[$];
  int   fail_cnt = 0;
  int   n_fits = 0;
  int   n_sent = 0;
  int   n_windows = 0;
  bit   quiet = 1'b0;
  bit   stim_done = 1'b0;

  function automatic logic [63:0] sqrt_floor(logic [63:0] q);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > q) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (q >= res + bit_v) begin
        q = q - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] slope_of_window();
    logic signed [127:0] n, d, e, f, sr, sc;
    logic [127:0]        me, mf;
    logic signed [63:0]  es, fs, num, den;
    logic [63:0]         un, ud, qm;
    n  = $signed({103'd0, n_pix});
    sr = $signed({91'd0, row_sum});
    sc = $signed({91'd0, col_sum});
    d  = $signed({79'd0, col_sq}) - $signed({79'd0, row_sq});
    e  = n * d - (sc * sc - sr * sr);
    f  = 2 * (n * $signed({79'd0, cross_sum}) - sr * sc);
    me = (e < 0) ? -e : e;
    mf = (f < 0) ? -f : f;
    while (me >= 128'h8000_0000 || mf >= 128'h8000_0000) begin
      me = me >> 1;
      mf = mf >> 1;
    end
    es = me[63:0];
    fs = mf[63:0];
    if (e < 0) es = -es;
    if (f < 0) fs = -fs;
    num = es - fs + $signed(sqrt_floor(me[63:0] * me[63:0] + mf[63:0] * mf[63:0]));
    den = es + fs - $signed(sqrt_floor(me[63:0] * me[63:0] + mf[63:0] * mf[63:0]));
    if (den == 0) begin
      if (num == 0) return 32'd0;
      return (num > 0) ? SLOPE_MAX : SLOPE_MIN;
    end
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    qm = (un << 16) / ud;
    if ((num < 0) != (den < 0)) begin
      if (qm > 64'h8000_0000) qm = 64'h8000_0000;
      return 32'(64'h1_0000_0000 - qm);
    end
    return (qm > 64'h7FFF_FFFF) ? SLOPE_MAX : qm[31:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] mean_sat(logic [63:0] s);
    logic [63:0] q;
    q = s / n_pix;
    return (q > CENT_MAX) ? FIELD_BITS'(CENT_MAX) : q[FIELD_BITS-1:0];
  endfunction

  function automatic void clear_moments();
    n_pix = 0; row_sum = 0; col_sum = 0;
    row_sq = 0; cross_sum = 0; col_sq = 0;
  endfunction

  // fold one accepted pixel into the sums; on window end return the fit
  function automatic bit accumulate_pixel(pix_row_t p, output fit_t fit);
    logic [23:0] r, c;
    r = {12'd0, p.row};
    c = {12'd0, p.col};
    if (p.on) begin
      n_pix     = n_pix + 1'b1;
      row_sum   = row_sum + r;
      col_sum   = col_sum + c;
      row_sq    = row_sq + r * r;
      cross_sum = cross_sum + r * c;
      col_sq    = col_sq + c * c;
    end
    if (!p.last) return 0;
    if (n_pix == 0) begin
      fit = '{slope: 0, crow: 0, ccol: 0, empty: 1'b1};
    end else begin
      fit.slope = slope_of_window();
      fit.crow  = mean_sat(64'(row_sum));
      fit.ccol  = mean_sat(64'(col_sum));
      fit.empty = 1'b0;
    end
    clear_moments();
    return 1;
  endfunction

  task automatic send_pixel(pix_row_t p);
    fit_t fit;
    in_pix.valid       <= 1'b1;
    in_pix.pixel_on    <= p.on;
    in_pix.pixel_row   <= p.row;
    in_pix.pixel_col   <= p.col;
    in_pix.window_last <= p.last;
    do @(posedge clk); while (!in_pix.ready);
    n_sent++;
    if (accumulate_pixel(p, fit)) begin
      n_windows++;
      if (p.known && fit != p.fit) begin
        $error("predictor disagrees with table row: slope %h crow %0d ccol %0d empty %0b",
               fit.slope, fit.crow, fit.ccol, fit.empty);
        fail_cnt++;
      end
      fit_q.push_back(p.known ? p.fit : fit);
    end
  endtask

  task automatic maybe_gap();
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic pix_row_t mk(bit on, int row, int col, bit last);
    pix_row_t p;
    p.on = on; p.row = FIELD_BITS'(row); p.col = FIELD_BITS'(col); p.last = last;
    p.known = 0; p.fit = '{slope: 0, crow: 0, ccol: 0, empty: 0};
    return p;
  endfunction

  function automatic pix_row_t mk_exp(bit on, int row, int col, bit last,
                                      logic [31:0] slope, int crow, int ccol, bit empty);
    pix_row_t p;
    p = mk(on, row, col, last);
    p.known = 1;
    p.fit = '{slope: slope, crow: FIELD_BITS'(crow), ccol: FIELD_BITS'(ccol), empty: empty};
    return p;
  endfunction

  pix_row_t directed[$];

  initial begin
    // empty window, single points at both corners
    directed.push_back(mk_exp(0, 4095, 4095, 1, 32'd0, 0, 0, 1));
    directed.push_back(mk_exp(1, 4095, 4095, 1, 32'd0, 4095, 4095, 0));
    directed.push_back(mk_exp(1, 0, 0, 1, 32'd0, 0, 0, 0));
    // constant row: zero denominator, positive saturation
    directed.push_back(mk(1, 5, 0, 0));
    directed.push_back(mk_exp(1, 5, 10, 1, SLOPE_MAX, 5, 5, 0));
    // constant column: zero over negative
    directed.push_back(mk(1, 0, 7, 0));
    directed.push_back(mk_exp(1, 10, 7, 1, 32'd0, 5, 7, 0));
    // off pixels are ignored, even at the extremes
    directed.push_back(mk(0, 4095, 0, 0));
    directed.push_back(mk(1, 0, 4095, 0));
    directed.push_back(mk(0, 0, 0, 0));
    directed.push_back(mk_exp(1, 0, 4095, 1, 32'd0, 0, 4095, 0));
    // diagonals and a spread over the full range
    directed.push_back(mk(1, 0, 0, 0));
    directed.push_back(mk(1, 4095, 4095, 1));
    directed.push_back(mk(1, 4095, 0, 0));
    directed.push_back(mk(1, 0, 4095, 1));
    directed.push_back(mk(1, 100, 200, 0));
    directed.push_back(mk(1, 300, 250, 0));
    directed.push_back(mk(1, 2048, 1024, 0));
    directed.push_back(mk(0, 1, 1, 1));
    // off-pixel last closes a non-empty window
    directed.push_back(mk(1, 17, 3000, 0));
    directed.push_back(mk(1, 19, 3001, 0));
    directed.push_back(mk(0, 4095, 4095, 1));
  end

  initial begin
    pix_row_t p;
    int len, kind, r0, c0, dr, dc, noise, k;
    in_pix.valid       <= 1'b0;
    in_pix.pixel_on    <= 1'b0;
    in_pix.pixel_row   <= '0;
    in_pix.pixel_col   <= '0;
    in_pix.window_last <= 1'b0;
    clear_moments();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_pixel(directed[i]);
      maybe_gap();
    end

    while (n_sent < N_ITEMS) begin
      if (n_sent > N_ITEMS * 85 / 100) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      r0 = $urandom_range(0, 4095);
      c0 = $urandom_range(0, 4095);
      dr = $urandom_range(0, 40) - 20;
      dc = $urandom_range(0, 40) - 20;
      noise = $urandom_range(0, 3);
      for (k = 0; k < len; k++) begin
        if (kind < 6) begin
          // points near a line through (r0, c0)
          p = mk($urandom_range(0, 9) != 0,
                 (r0 + k * dr + $urandom_range(0, 2 * noise) - noise) & 12'hFFF,
                 (c0 + k * dc + $urandom_range(0, 2 * noise) - noise) & 12'hFFF,
                 k == len - 1);
        end else if (kind < 9) begin
          p = mk($urandom_range(0, 2) != 0, $urandom_range(0, 4095),
                 $urandom_range(0, 4095), k == len - 1);
        end else begin
          // sparse window, often empty
          p = mk($urandom_range(0, 15) == 0, $urandom_range(0, 4095),
                 $urandom_range(0, 4095), k == len - 1);
        end
        send_pixel(p);
        maybe_gap();
      end
    end
    in_pix.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // result side: random stalls plus one long hold-off to fill the queue
  initial begin
    int  hold;
    bit  held_long;
    bit  rdy_next;
    fit_t exp_fit;
    hold = 0;
    held_long = 0;
    out_fit.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_fit.valid && out_fit.ready) begin
        n_fits++;
        if (fit_q.size() == 0) begin
          $error("fit item with nothing expected");
          fail_cnt++;
        end else begin
          exp_fit = fit_q.pop_front();
          if (out_fit.fit_slope !== exp_fit.slope) begin
            $error("fit_slope expected %h actual %h", exp_fit.slope, out_fit.fit_slope);
            fail_cnt++;
          end
          if (out_fit.centroid_row !== exp_fit.crow) begin
            $error("centroid_row expected %0d actual %0d", exp_fit.crow,
                   out_fit.centroid_row);
            fail_cnt++;
          end
          if (out_fit.centroid_col !== exp_fit.ccol) begin
            $error("centroid_col expected %0d actual %0d", exp_fit.ccol,
                   out_fit.centroid_col);
            fail_cnt++;
          end
          if (out_fit.window_empty !== exp_fit.empty) begin
            $error("window_empty expected %0b actual %0b", exp_fit.empty,
                   out_fit.window_empty);
            fail_cnt++;
          end
        end
      end
      rdy_next = 1'b1;
      if (!held_long && n_fits == 20) begin
        held_long = 1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        rdy_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 15) - 1;
        rdy_next = 1'b0;
      end
      out_fit.ready <= rdy_next;
    end
  end

  initial begin
    wait (stim_done);
    while (fit_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d pixels in %0d windows, checked %0d fits (%0d mismatches).",
             n_sent, n_windows, n_fits, fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS principal_axis_line_fit_top");
    end else begin
      $display("FAIL principal_axis_line_fit_top");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d fits outstanding.", fit_q.size());
    $display("FAIL principal_axis_line_fit_top");
    $finish;
  end

endmodule
